/* design/idsu_pkg.sv */
// ----------------------------------------------------------------------------
// Integer divider package
// Shared widths, request codes and the control bundle that steers the cells.
// ----------------------------------------------------------------------------
package idsu_pkg;

	localparam int unsigned DATA_W   = 64;
	localparam int unsigned HALF_W   = 32;
	localparam int unsigned CELL_W   = 8;
	localparam int unsigned CNT_W    = $clog2(DATA_W + 1);

	localparam logic [1:0] REQ_U32 = 2'd0;
	localparam logic [1:0] REQ_S32 = 2'd1;
	localparam logic [1:0] REQ_U64 = 2'd2;
	localparam logic [1:0] REQ_S64 = 2'd3;

	// Control shared by every cell of the remainder/quotient row.
	typedef struct packed {
		logic load;
		logic step;
		logic take;
	} cell_ctl_t;

endpackage

/* design/idsu_req_if.sv */
// ----------------------------------------------------------------------------
// Divider request channel
// Valid/ready channel carrying the operation code and both operands.
// ----------------------------------------------------------------------------
interface idsu_req_if import idsu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [DATA_W-1:0] dividend_value;
	logic [DATA_W-1:0] divisor_value;

	modport source (output valid, output req_type, output dividend_value,
		output divisor_value, input ready);
	modport sink (input valid, input req_type, input dividend_value,
		input divisor_value, output ready);
endinterface

/* design/idsu_rsp_if.sv */
// ----------------------------------------------------------------------------
// Divider response channel
// Valid/ready channel carrying the quotient, remainder and zero-divisor flag.
// ----------------------------------------------------------------------------
interface idsu_rsp_if import idsu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] quotient_value;
	logic [DATA_W-1:0] remainder_value;
	logic              div_by_zero;

	modport source (output valid, output quotient_value, output remainder_value,
		output div_by_zero, input ready);
	modport sink (input valid, input quotient_value, input remainder_value,
		input div_by_zero, output ready);
endinterface

/* design/integer_divider_signed_unsigned.sv */
// ----------------------------------------------------------------------------
// Integer divider, signed and unsigned, 32-bit and 64-bit
// Shift-subtract divider built from a row of remainder/quotient cells.
// ----------------------------------------------------------------------------
// A request is taken only while the divider is idle. The operands are prepared
// and loaded into the cell row at the edge that accepts the request. The row
// then works one quotient bit per cycle through every bit of the 32-bit or
// 64-bit dividend, and a fix-up state then corrects the signs and writes the
// result into the output register once that register is free; a zero divisor
// skips the row and goes straight to the fix-up state. The result sits in an
// output register, so the next request is taken while it waits to be
// collected. The quotient truncates towards zero, the remainder has the sign
// of the dividend, and the minimum value divided by minus one wraps to the
// minimum value.
module integer_divider_signed_unsigned import idsu_pkg::*; #(
	parameter int unsigned SLICE_W = CELL_W
) (
	input  logic clk,
	input  logic arst_n,
	idsu_req_if.sink   req,
	idsu_rsp_if.source rsp
);

	localparam int unsigned NCELL = DATA_W / SLICE_W;
	localparam logic [CNT_W-1:0] CNT_WIDE   = CNT_W'(DATA_W);
	localparam logic [CNT_W-1:0] CNT_NARROW = CNT_W'(HALF_W);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIX} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] dvs_q;
	logic              wide_q;
	logic              neg_q_q;
	logic              neg_r_q;
	logic              dz_q;
	logic              out_vld_q;
	logic [DATA_W-1:0] out_quo_q;
	logic [DATA_W-1:0] out_rem_q;
	logic              out_dz_q;

	// Operand preparation
	logic              acc;
	logic              wide;
	logic              sgn;
	logic [DATA_W-1:0] wmask;
	logic [DATA_W-1:0] n_m;
	logic [DATA_W-1:0] d_m;
	logic              nneg;
	logic              dneg;
	logic [DATA_W-1:0] n_mag;
	logic [DATA_W-1:0] d_mag;
	logic [DATA_W-1:0] load_quo;

	// Cell row
	cell_ctl_t         ctl;
	logic [NCELL-1:0]  rem_msb;
	logic [NCELL-1:0]  quo_msb;
	logic [NCELL-1:0]  borrow;
	logic [DATA_W-1:0] rem_all;
	logic [DATA_W-1:0] quo_all;

	// Sign fix-up
	logic [DATA_W-1:0] fmask;
	logic [DATA_W-1:0] q_fix;
	logic [DATA_W-1:0] r_fix;
	logic              out_free;

	assign acc   = req.valid && req.ready;
	assign wide  = (req.req_type == REQ_U64) || (req.req_type == REQ_S64);
	assign sgn   = (req.req_type == REQ_S32) || (req.req_type == REQ_S64);
	assign wmask = wide ? '1 : {{(DATA_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
	assign n_m   = req.dividend_value & wmask;
	assign d_m   = req.divisor_value & wmask;
	assign nneg  = sgn && (wide ? n_m[DATA_W-1] : n_m[HALF_W-1]);
	assign dneg  = sgn && (wide ? d_m[DATA_W-1] : d_m[HALF_W-1]);
	assign n_mag = nneg ? ((~n_m + 1'b1) & wmask) : n_m;
	assign d_mag = dneg ? ((~d_m + 1'b1) & wmask) : d_m;
	// A 32-bit dividend sits in the upper half so that its top bit leaves first.
	assign load_quo = wide ? n_mag : (n_mag << HALF_W);

	// A quotient bit is taken when the shifted remainder overflowed or the
	// trial subtraction across the whole row produced no borrow.
	assign ctl.load = acc;
	assign ctl.step = (state_q == ST_RUN);
	assign ctl.take = rem_msb[NCELL-1] || !borrow[NCELL-1];

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic rem_in;
		logic quo_in;
		logic borrow_in;

		if (i == 0) begin : g_first
			assign rem_in    = quo_msb[NCELL-1];
			assign quo_in    = ctl.take;
			assign borrow_in = 1'b0;
		end else begin : g_rest
			assign rem_in    = rem_msb[i-1];
			assign quo_in    = quo_msb[i-1];
			assign borrow_in = borrow[i-1];
		end

		idsu_cell #(.SLICE_W(SLICE_W)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.load_quo   (load_quo[i*SLICE_W +: SLICE_W]),
			.divisor    (dvs_q[i*SLICE_W +: SLICE_W]),
			.rem_in     (rem_in),
			.quo_in     (quo_in),
			.borrow_in  (borrow_in),
			.rem_msb    (rem_msb[i]),
			.quo_msb    (quo_msb[i]),
			.borrow_out (borrow[i]),
			.rem        (rem_all[i*SLICE_W +: SLICE_W]),
			.quo        (quo_all[i*SLICE_W +: SLICE_W])
		);
	end

	assign fmask    = wide_q ? '1 : {{(DATA_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
	assign q_fix    = (neg_q_q ? (~quo_all + 1'b1) : quo_all) & fmask;
	assign r_fix    = (neg_r_q ? (~rem_all + 1'b1) : rem_all) & fmask;
	assign out_free = !out_vld_q || rsp.ready;

	assign req.ready           = (state_q == ST_IDLE);
	assign rsp.valid           = out_vld_q;
	assign rsp.quotient_value  = out_quo_q;
	assign rsp.remainder_value = out_rem_q;
	assign rsp.div_by_zero     = out_dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// A new result replaces the one being collected in the same cycle.
			if ((state_q == ST_FIX) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						dvs_q   <= d_mag;
						wide_q  <= wide;
						neg_q_q <= nneg != dneg;
						neg_r_q <= nneg;
						dz_q    <= (d_m == '0);
						cnt_q   <= wide ? CNT_WIDE : CNT_NARROW;
						state_q <= (d_m == '0) ? ST_FIX : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (out_free) begin
						out_quo_q <= dz_q ? '0 : q_fix;
						out_rem_q <= dz_q ? '0 : r_fix;
						out_dz_q  <= dz_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/idsu_cell.sv */
// ----------------------------------------------------------------------------
// Divider cell
// One slice of the partial remainder and of the dividend/quotient shift
// register, with its slice of the trial subtraction.
// ----------------------------------------------------------------------------
module idsu_cell import idsu_pkg::*; #(
	parameter int unsigned SLICE_W = CELL_W
) (
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic [SLICE_W-1:0] load_quo,
	input  logic [SLICE_W-1:0] divisor,
	input  logic               rem_in,
	input  logic               quo_in,
	input  logic               borrow_in,
	output logic               rem_msb,
	output logic               quo_msb,
	output logic               borrow_out,
	output logic [SLICE_W-1:0] rem,
	output logic [SLICE_W-1:0] quo
);

	logic [SLICE_W-1:0] rem_q;
	logic [SLICE_W-1:0] quo_q;
	logic [SLICE_W-1:0] shifted;
	logic [SLICE_W:0]   diff_w;

	assign shifted = {rem_q[SLICE_W-2:0], rem_in};
	assign diff_w  = {1'b0, shifted} - {1'b0, divisor} - {{SLICE_W{1'b0}}, borrow_in};

	assign borrow_out = diff_w[SLICE_W];
	assign rem_msb    = rem_q[SLICE_W-1];
	assign quo_msb    = quo_q[SLICE_W-1];
	assign rem        = rem_q;
	assign quo        = quo_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			quo_q <= load_quo;
		end else if (ctl.step) begin
			rem_q <= ctl.take ? diff_w[SLICE_W-1:0] : shifted;
			quo_q <= {quo_q[SLICE_W-2:0], quo_in};
		end
	end

endmodule

/* design/idsu_checker.sv */
// ----------------------------------------------------------------------------
// Integer divider port checker
// Watches the request and response channels of the divider.
// ----------------------------------------------------------------------------
module idsu_checker import idsu_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [DATA_W-1:0] quotient_value,
	input logic [DATA_W-1:0] remainder_value,
	input logic              div_by_zero
);

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Transactions accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (rsp_acc && !req_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_zero_results: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && div_by_zero |-> quotient_value == '0 && remainder_value == '0)
		else $error("zero divisor response carries nonzero results");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(quotient_value)
		&& $stable(remainder_value) && $stable(div_by_zero))
		else $error("stalled response changed");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an outstanding request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two transactions outstanding");

endmodule

bind integer_divider_signed_unsigned idsu_checker u_idsu_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.quotient_value  (rsp.quotient_value),
	.remainder_value (rsp.remainder_value),
	.div_by_zero     (rsp.div_by_zero)
);
